### src/byte_stuffing_framer_parity_unit_macros.svh
// Assertion macros used by the checker file of the framer.
// No dependencies; take in by include inside a module body.
`ifndef BYTE_STUFFING_FRAMER_PARITY_UNIT_MACROS_SVH
`define BYTE_STUFFING_FRAMER_PARITY_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define BSFP_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: label");

// Next-cycle implication, off while reset is high.
`define BSFP_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: label");

// Next-cycle implication that also holds across reset.
`define BSFP_ASSERT_NEXT_ALWAYS(label, clk, cond, prop) \
   label: assert property (@(posedge clk) (cond) |=> (prop)) \
      else $error("assertion failed: label");

`endif

### src/bsfp_pkg.sv
// Types and constants for the byte stuffing framer with parity trailer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsfp_pkg;

   localparam int BYTE_W      = 8;
   localparam int MAX_RESULTS = 3;
   localparam int COUNT_W     = 2;
   localparam int CSR_IDX_W   = 1;

   localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'h24;
   localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h2F;

   localparam logic [CSR_IDX_W-1:0] CSR_FLAG   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE = 1'd1;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_END  = 1'b1;

   typedef struct packed {
      logic              func;
      logic [BYTE_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              is_trailer;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [BYTE_W-1:0] flag_value;
      logic [BYTE_W-1:0] escape_value;
   } cfg_type;

   // Result bytes of one request, left justified, trailer only ever last.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][BYTE_W-1:0] bytes;
      logic [COUNT_W-1:0]                 count;
      logic                               has_trailer;
   } burst_type;

   typedef struct packed {
      logic      valid;
      burst_type burst;
   } hand_type;

endpackage

`default_nettype wire

### src/bsfp_csr.sv
// Configuration registers: flag and escape byte values.
// Depends on bsfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsfp_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [bsfp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bsfp_pkg::BYTE_W-1:0]      csr_data,
   output bsfp_pkg::cfg_type                     cfg
);
   import bsfp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FLAG:   cfg_in.flag_value   = csr_data;
            CSR_ESCAPE: cfg_in.escape_value = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_value   <= FLAG_RESET;
         cfg_ff.escape_value <= ESCAPE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### src/bsfp_encode.sv
// Frame state, stuffing and parity for one request, held in a pending register.
// Depends on bsfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsfp_encode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bsfp_pkg::cfg_type cfg,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire bsfp_pkg::req_type req_payload,
   output bsfp_pkg::hand_type     pend,
   input  wire logic              pend_take
);
   import bsfp_pkg::*;

   logic              in_frame_ff, in_frame_in;
   logic [BYTE_W-1:0] parity_ff, parity_in;
   logic              pend_valid_ff, pend_valid_in;
   burst_type         pend_ff, pend_in;

   logic              accept;
   logic              start;
   logic              hit;
   logic [BYTE_W-1:0] par_base;
   logic [BYTE_W-1:0] start_term;
   logic [BYTE_W-1:0] flag_v;
   logic [BYTE_W-1:0] esc_v;
   logic [BYTE_W-1:0] data_v;
   burst_type         enc;
   logic [BYTE_W-1:0] enc_parity;

   assign req_stall = pend_valid_ff & ~pend_take;
   assign accept    = req_valid & ~req_stall;

   assign flag_v     = cfg.flag_value;
   assign esc_v      = cfg.escape_value;
   assign data_v     = req_payload.data_byte;
   assign start      = ~in_frame_ff;
   assign par_base   = start ? '0 : parity_ff;
   assign start_term = start ? flag_v : '0;
   assign hit        = (data_v == flag_v) | (data_v == esc_v);

   always_comb begin
      enc        = '0;
      enc_parity = '0;
      case (req_payload.func)
         FUNC_BYTE: begin
            enc_parity = par_base ^ start_term ^ (hit ? esc_v : '0) ^ data_v;
            if (start) begin
               enc.bytes[0] = flag_v;
               if (hit) begin
                  enc.bytes[1] = esc_v;
                  enc.bytes[2] = data_v;
                  enc.count    = COUNT_W'(3);
               end else begin
                  enc.bytes[1] = data_v;
                  enc.count    = COUNT_W'(2);
               end
            end else if (hit) begin
               enc.bytes[0] = esc_v;
               enc.bytes[1] = data_v;
               enc.count    = COUNT_W'(2);
            end else begin
               enc.bytes[0] = data_v;
               enc.count    = COUNT_W'(1);
            end
         end
         default: begin
            // end of frame: closing flag, then the trailer over the whole frame
            enc.has_trailer = 1'b1;
            if (start) begin
               enc.bytes[0] = flag_v;
               enc.bytes[1] = flag_v;
               enc.bytes[2] = par_base ^ start_term ^ flag_v;
               enc.count    = COUNT_W'(3);
            end else begin
               enc.bytes[0] = flag_v;
               enc.bytes[1] = par_base ^ flag_v;
               enc.count    = COUNT_W'(2);
            end
         end
      endcase
   end

   always_comb begin
      in_frame_in   = in_frame_ff;
      parity_in     = parity_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (accept) begin
         pend_valid_in = 1'b1;
         pend_in       = enc;
         in_frame_in   = (req_payload.func == FUNC_BYTE);
         parity_in     = enc_parity;
      end else if (pend_take) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         parity_ff     <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         in_frame_ff   <= in_frame_in;
         parity_ff     <= parity_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

   assign pend.valid = pend_valid_ff;
   assign pend.burst = pend_ff;

endmodule

`default_nettype wire

### src/bsfp_emit.sv
// Result register: sends the bytes of one burst, one per cycle while rsp_stall is low.
// Depends on bsfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsfp_emit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bsfp_pkg::hand_type pend,
   output logic                    pend_take,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output bsfp_pkg::rsp_type       rsp_payload
);
   import bsfp_pkg::*;

   logic               cur_valid_ff, cur_valid_in;
   burst_type          cur_ff, cur_in;
   logic [COUNT_W-1:0] ptr_ff, ptr_in;

   logic              out_take;
   logic              at_end;
   logic              free;
   logic [BYTE_W-1:0] out_byte;

   assign out_take  = cur_valid_ff & ~rsp_stall;
   assign at_end    = ((ptr_ff + COUNT_W'(1)) == cur_ff.count);
   assign free      = ~cur_valid_ff | (out_take & at_end);
   assign pend_take = free & pend.valid;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      ptr_in       = ptr_ff;
      if (free) begin
         cur_valid_in = pend.valid;
         cur_in       = pend.burst;
         ptr_in       = '0;
      end else if (out_take) begin
         ptr_in = ptr_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         ptr_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         ptr_ff       <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_comb begin
      case (ptr_ff)
         2'd0:    out_byte = cur_ff.bytes[0];
         2'd1:    out_byte = cur_ff.bytes[1];
         default: out_byte = cur_ff.bytes[2];
      endcase
   end

   assign rsp_payload.out_byte   = out_byte;
   assign rsp_payload.is_trailer = cur_ff.has_trailer & at_end;
   assign rsp_payload.last       = at_end;
   assign rsp_valid              = cur_valid_ff;

endmodule

`default_nettype wire

### src/byte_stuffing_framer_parity_unit.sv
// Top level of the byte stuffing framer with XOR parity trailer.
// Depends on bsfp_pkg, bsfp_csr, bsfp_encode and bsfp_emit.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   func, data_byte
//   rsp_      out        rsp_valid/rsp_stall   out_byte, is_trailer, last
//   csr_      in         csr_write_enable      csr_index, csr_data
//
// A request gives one to three result bytes; the single output byte lane sends
// one per cycle while rsp_stall is low.
// The first result passes through the pending register, then the result
// register, before it is offered on rsp_.
// Reset (synchronous) closes any open frame, clears the parity and the
// pipeline, and restores the flag and escape values.
// A stall on rsp_ holds the result; one further request is held in the
// pending register before req_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module byte_stuffing_framer_parity_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire bsfp_pkg::req_type              req_payload,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output bsfp_pkg::rsp_type                   rsp_payload,
   input  wire logic                           csr_write_enable,
   input  wire logic [bsfp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bsfp_pkg::BYTE_W-1:0]    csr_data
);
   import bsfp_pkg::*;

   cfg_type  cfg;
   hand_type pend;
   logic     pend_take;

   // flag and escape values; the user must write them only while the framer is idle, the block does not enforce it
   bsfp_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   // open the frame, stuff the byte or close the frame, and advance parity
   bsfp_encode u_encode (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .pend        (pend),
      .pend_take   (pend_take)
   );

   // hand the burst of the oldest request out one byte at a time
   bsfp_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .pend        (pend),
      .pend_take   (pend_take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

### src/bsfp_checker.sv
// Port-level checks on the framer result channel, bound to the top level.
// Depends on bsfp_pkg and byte_stuffing_framer_parity_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module bsfp_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire bsfp_pkg::rsp_type rsp_payload
);
   import bsfp_pkg::*;
   `include "byte_stuffing_framer_parity_unit_macros.svh"

   // hold a stalled result unchanged
   `BSFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   // the trailer always closes the burst of its request
   `BSFP_ASSERT_IMPLY(a_trailer_last, clock, reset, rsp_valid && rsp_payload.is_trailer, rsp_payload.last)
   // a burst runs without gaps until its last byte
   `BSFP_ASSERT_NEXT(a_burst_gapless, clock, reset, rsp_valid && !rsp_stall && !rsp_payload.last, rsp_valid)
   // drop every result on reset
   `BSFP_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind byte_stuffing_framer_parity_unit bsfp_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

### sim/tb_byte_stuffing_framer_parity_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for the byte stuffing framer with XOR parity trailer.
// Depends on bsfp_pkg and byte_stuffing_framer_parity_unit; the framed stream
// is predicted as requests are accepted and compared byte by byte on rsp_.

module tb_byte_stuffing_framer_parity_unit;
   import bsfp_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int MAX_SHOWN      = 10;
   localparam int SETTLE_CYCLES  = 4;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_REQUESTS = 60;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   req_type              req_payload      = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [BYTE_W-1:0]    csr_data         = '0;

   // Shadow copy of the framer: register values, open frame and its parity.
   logic [BYTE_W-1:0] flag_byte    = FLAG_RESET;
   logic [BYTE_W-1:0] escape_byte  = ESCAPE_RESET;
   logic [BYTE_W-1:0] frame_parity = '0;
   logic              frame_open   = 1'b0;

   // Framed bytes still owed by the block, oldest first.
   rsp_type framed_q[$];

   bit idle_on     = 1'b1;  // both sides draw random gaps while set
   int mismatches  = 0;
   int cycle_count = 0;
   int stall_left  = 0;

   byte_stuffing_framer_parity_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Give up on a hung run; a correct run finishes far below the limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Queue one framed byte; the parity covers every byte except the trailer.
   task automatic emit_byte(input logic [BYTE_W-1:0] value, input logic trailer);
      rsp_type res;
      res.out_byte   = value;
      res.is_trailer = trailer;
      res.last       = 1'b0;
      if (!trailer)
         frame_parity = frame_parity ^ value;
      framed_q = {framed_q, res};
   endtask

   // Work out the bytes one accepted request causes and advance the shadow state.
   task automatic frame_request(input req_type item);
      // No frame open: lead with the start flag and restart the parity.
      if (!frame_open) begin
         frame_parity = '0;
         emit_byte(flag_byte, 1'b0);
         frame_open = 1'b1;
      end
      if (item.func == FUNC_BYTE) begin
         // One escape in front, even where flag and escape are the same value.
         if (item.data_byte == flag_byte || item.data_byte == escape_byte)
            emit_byte(escape_byte, 1'b0);
         emit_byte(item.data_byte, 1'b0);
      end else begin
         // Close: flag, then the parity of everything sent in this frame.
         emit_byte(flag_byte, 1'b0);
         emit_byte(frame_parity, 1'b1);
         frame_open   = 1'b0;
         frame_parity = '0;
      end
      // Mark the final byte of this request.
      framed_q[framed_q.size() - 1].last = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Result side: stall at random, compare each accepted byte
   // ------------------------------------------------------------------

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (framed_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("cycle %0d: unexpected byte %02h trailer %0b last %0b",
                           cycle_count, rsp_payload.out_byte,
                           rsp_payload.is_trailer, rsp_payload.last);
            end else begin
               want = framed_q.pop_front();
               if (rsp_payload.out_byte !== want.out_byte ||
                   rsp_payload.is_trailer !== want.is_trailer ||
                   rsp_payload.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= MAX_SHOWN)
                     $display("cycle %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                              cycle_count, want.out_byte, want.is_trailer, want.last,
                              rsp_payload.out_byte, rsp_payload.is_trailer,
                              rsp_payload.last);
               end
            end
            // Draw the hold-off before the next byte is taken.
            stall_left = idle_on ? $urandom_range(0, 9) : 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Shared driving tasks; each is entered and left at a rising edge
   // ------------------------------------------------------------------

   function automatic req_type make_req(input logic func, input logic [BYTE_W-1:0] data);
      req_type item;
      item.func      = func;
      item.data_byte = data;
      return item;
   endfunction

   // Offer one request and hold it until accepted. Valid is left high so that a
   // back-to-back request needs no second assignment in the same step.
   task automatic send_request(input req_type item);
      int gap;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do
         @(posedge clock);
      while (req_stall);
      frame_request(item);
   endtask

   // Drop valid and hold until every owed byte has come, then let the block settle.
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (framed_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the enable is low again before the task returns.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [BYTE_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (index == CSR_FLAG)
         flag_byte = value;
      else if (index == CSR_ESCAPE)
         escape_byte = value;
   endtask

   // Change both framing values once the block has gone quiet.
   task automatic set_framing(input logic [BYTE_W-1:0] flag, input logic [BYTE_W-1:0] esc);
      wait_for_quiet();
      write_reg(CSR_FLAG, flag);
      write_reg(CSR_ESCAPE, esc);
   endtask

   // Payload bytes lean towards the current flag and escape values and the extremes.
   function automatic logic [BYTE_W-1:0] payload_byte();
      case ($urandom_range(0, 7))
         0: return flag_byte;
         1: return escape_byte;
         2: return '0;
         3: return '1;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset values: plain and escaped bytes, an empty frame, a frame opened by a
   // byte that needs escaping (three bytes from one request).
   task automatic test_default_framing();
      send_request(make_req(FUNC_BYTE, 8'h00));
      send_request(make_req(FUNC_BYTE, FLAG_RESET));
      send_request(make_req(FUNC_BYTE, ESCAPE_RESET));
      send_request(make_req(FUNC_BYTE, 8'hFF));
      send_request(make_req(FUNC_BYTE, 8'h5A));
      send_request(make_req(FUNC_END, 8'hFF));
      send_request(make_req(FUNC_END, 8'h00));
      send_request(make_req(FUNC_BYTE, FLAG_RESET));
      send_request(make_req(FUNC_BYTE, 8'hA5));
      send_request(make_req(FUNC_END, 8'h3C));
   endtask

   // Register extremes, then flag equal to escape: a matching byte gets one escape.
   task automatic test_register_extremes();
      set_framing(8'h00, 8'hFF);
      send_request(make_req(FUNC_BYTE, 8'h00));
      send_request(make_req(FUNC_BYTE, 8'hFF));
      send_request(make_req(FUNC_BYTE, 8'h80));
      send_request(make_req(FUNC_END, 8'h00));
      set_framing(8'hFF, 8'hFF);
      send_request(make_req(FUNC_BYTE, 8'hFF));
      send_request(make_req(FUNC_BYTE, 8'h01));
      send_request(make_req(FUNC_END, 8'hFF));
   endtask

   // Leave a frame open across a register change; later bytes use the new values.
   task automatic test_change_mid_frame();
      set_framing(FLAG_RESET, ESCAPE_RESET);
      send_request(make_req(FUNC_BYTE, 8'h11));
      set_framing(8'h55, 8'hAA);
      send_request(make_req(FUNC_BYTE, 8'h55));
      send_request(make_req(FUNC_BYTE, FLAG_RESET));
      send_request(make_req(FUNC_END, 8'h77));
   endtask

   // Mostly well-formed frames of random length with random content, plus runs
   // of empty frames and frames cut off by a register change between phases.
   // Once per phase the sender holds until every owed byte has come.
   task automatic test_random_traffic();
      logic [BYTE_W-1:0] same;
      int pause_at;
      int frame_left;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: set_framing(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
            1: set_framing(8'hFF, 8'h00);
            2: begin
               same = BYTE_W'($urandom_range(0, 255));
               set_framing(same, same);
            end
            3: set_framing(8'h00, 8'h01);
            4: set_framing(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
            default: set_framing(FLAG_RESET, ESCAPE_RESET);
         endcase
         // Run two phases flat out on both sides.
         idle_on    = (phase != 1 && phase != 4);
         pause_at   = $urandom_range(10, PHASE_REQUESTS - 10);
         frame_left = $urandom_range(0, 8);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (n == pause_at)
               wait_for_quiet();
            if (frame_left > 0) begin
               send_request(make_req(FUNC_BYTE, payload_byte()));
               frame_left--;
            end else begin
               // Close with a junk data field; the next frame may be empty.
               send_request(make_req(FUNC_END, BYTE_W'($urandom_range(0, 255))));
               frame_left = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30)
                                                        : $urandom_range(0, 8);
            end
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_default_framing();
      test_register_extremes();
      test_change_mid_frame();
      test_random_traffic();

      wait_for_quiet();
      mismatches += framed_q.size();
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
